FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define MFLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define MFLD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/mfld_pkg.sv
// ----------------------------------------------------------------------------
// mfld_pkg
// Types, constants and name tables for the mbox separator line detector.
// ----------------------------------------------------------------------------
package mfld_pkg;

  // Verdict codes carried on the result channel
  typedef enum logic [1:0] {
    V_START     = 2'd0,
    V_NOTSEP    = 2'd1,
    V_NOSPACE   = 2'd2,
    V_UNDECIDED = 2'd3
  } verdict_e;

  // Parse phases, one-hot
  typedef enum logic [11:0] {
    PH_PREFIX   = 12'b0000_0000_0001,
    PH_ADDRLEAD = 12'b0000_0000_0010,
    PH_ADDR     = 12'b0000_0000_0100,
    PH_WDLEAD   = 12'b0000_0000_1000,
    PH_WDAY     = 12'b0000_0001_0000,
    PH_MOLEAD   = 12'b0000_0010_0000,
    PH_MONTH    = 12'b0000_0100_0000,
    PH_DAY      = 12'b0000_1000_0000,
    PH_HOUR     = 12'b0001_0000_0000,
    PH_MIN      = 12'b0010_0000_0000,
    PH_SEC      = 12'b0100_0000_0000,
    PH_YEAR     = 12'b1000_0000_0000
  } phase_e;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned NumNames   = 12;   // widest name table (months)
  localparam int unsigned NumDays    = 7;
  localparam int unsigned NameLen    = 3;
  localparam int unsigned NumWidth   = 7;

  localparam logic [2:0]          PREFIX_LEN = 3'd5;
  localparam logic [2:0]          NAME_LEN   = 3'(NameLen);
  localparam logic [NumNames-1:0] ALL_CANDS  = '1;
  localparam logic [NumWidth-1:0] NUM_SAT    = 7'd127;
  localparam logic [NumWidth-1:0] DAY_MIN    = 7'd1;
  localparam logic [NumWidth-1:0] DAY_MAX    = 7'd31;
  localparam logic [NumWidth-1:0] HOUR_MAX   = 7'd23;
  localparam logic [NumWidth-1:0] MINSEC_MAX = 7'd59;

  // One input transaction held in the input register
  typedef struct packed {
    logic [CharWidth-1:0] char_byte;
    logic                 end_of_line;
  } item_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } result_t;

  // Character of "From " at a position; zero past the end
  function automatic logic [CharWidth-1:0] prefix_char(input logic [2:0] pos);
    logic [CharWidth-1:0] ch;
    case (pos)
      3'd0:    ch = "F";
      3'd1:    ch = "r";
      3'd2:    ch = "o";
      3'd3:    ch = "m";
      3'd4:    ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Weekday names, first letter in the top byte
  function automatic logic [23:0] day_name(input logic [2:0] idx);
    logic [23:0] nm;
    case (idx)
      3'd0:    nm = "Sun";
      3'd1:    nm = "Mon";
      3'd2:    nm = "Tue";
      3'd3:    nm = "Wed";
      3'd4:    nm = "Thu";
      3'd5:    nm = "Fri";
      3'd6:    nm = "Sat";
      default: nm = 24'h0;
    endcase
    return nm;
  endfunction

  // Month names, first letter in the top byte
  function automatic logic [23:0] month_name(input logic [3:0] idx);
    logic [23:0] nm;
    case (idx)
      4'd0:    nm = "Jan";
      4'd1:    nm = "Feb";
      4'd2:    nm = "Mar";
      4'd3:    nm = "Apr";
      4'd4:    nm = "May";
      4'd5:    nm = "Jun";
      4'd6:    nm = "Jul";
      4'd7:    nm = "Aug";
      4'd8:    nm = "Sep";
      4'd9:    nm = "Oct";
      4'd10:   nm = "Nov";
      4'd11:   nm = "Dec";
      default: nm = 24'h0;
    endcase
    return nm;
  endfunction

  // Which names carry character ch at position pos (pos is 0..2)
  function automatic logic [NumNames-1:0] name_hits(input logic                 is_month,
                                                    input logic [1:0]           pos,
                                                    input logic [CharWidth-1:0] ch);
    logic [NumNames-1:0] hits;
    logic [23:0]         nm;
    hits = '0;
    for (int i = 0; i < NumNames; i++) begin
      if (is_month) begin
        nm = month_name(4'(i));
      end else if (i < NumDays) begin
        nm = day_name(3'(i));
      end else begin
        nm = 24'h0;
      end
      hits[i] = (is_month || i < NumDays) && (nm[8*(2-int'(pos)) +: 8] == ch);
    end
    return hits;
  endfunction

endpackage

FILE: src/mfld_in_stage.sv
// ----------------------------------------------------------------------------
// mfld_in_stage
// Input register: holds one character transaction until the parser takes it.
// ----------------------------------------------------------------------------
module mfld_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_byte_i,
  input  logic                   end_of_line_i,
  input  logic                   take_i,
  output logic                   item_valid_o,
  output mfld_pkg::item_t        item_o
);
  import mfld_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held transaction cannot move on
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.char_byte   <= char_byte_i;
      item_q.end_of_line <= end_of_line_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: src/mfld_parser.sv
// ----------------------------------------------------------------------------
// mfld_parser
// Line state machine: consumes one character per cycle unless a line end waits
// for room in the result register, and yields the verdict on the line's last character.
// ----------------------------------------------------------------------------
module mfld_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  mfld_pkg::item_t        item_i,
  input  logic                   out_free_i,
  output logic                   take_o,
  output mfld_pkg::result_t      result_o
);
  import mfld_pkg::*;

  phase_e              phase_q, phase_d;
  logic [2:0]          pos_q, pos_d;
  logic [NumNames-1:0] cand_q, cand_d;
  logic [NumWidth-1:0] num_q, num_d;
  logic                seen_q, seen_d;
  verdict_e            held_q, held_d;

  // A line end needs room in the output register
  assign take_o = item_valid_i && (!item_i.end_of_line || out_free_i);

  always_comb begin
    logic [CharWidth-1:0] c;
    logic                 blank;
    logic                 ws;
    logic                 digit;
    logic [10:0]          prod;
    logic                 name_go;
    logic                 is_month;
    logic [2:0]           npos;
    logic [NumNames-1:0]  ncand;
    logic [NumNames-1:0]  keep;
    logic                 in_range;
    logic                 colon_next;
    phase_e               num_next;

    c          = item_i.char_byte;
    blank      = (c == " ") || (c == 8'h09);
    ws         = (c == " ") || (c >= 8'h09 && c <= 8'h0d);
    digit      = (c >= "0") && (c <= "9");
    prod       = 11'(num_q) * 11'd10 + 11'(c[3:0]);
    name_go    = 1'b0;
    is_month   = 1'b0;
    npos       = pos_q;
    ncand      = cand_q;
    keep       = '0;
    in_range   = 1'b0;
    colon_next = 1'b0;
    num_next   = PH_HOUR;

    phase_d  = phase_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    num_d    = num_q;
    seen_d   = seen_q;
    held_d   = held_q;
    result_o = '{valid: 1'b0, verdict: V_NOTSEP};

    if (take_o && held_q == V_UNDECIDED) begin
      case (phase_q)
        // Literal "From "
        PH_PREFIX: begin
          if (pos_q < PREFIX_LEN && prefix_char(pos_q) == c) begin
            if (pos_q == PREFIX_LEN - 3'd1) begin
              pos_d   = '0;
              phase_d = PH_ADDRLEAD;
            end else begin
              pos_d = pos_q + 3'd1;
            end
          end else begin
            held_d = V_NOTSEP;
          end
        end
        PH_ADDRLEAD: begin
          if (!blank) begin
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (blank) begin
            phase_d = PH_WDLEAD;
          end
        end
        // Blanks before a name; first letter starts a fresh match
        PH_WDLEAD: begin
          if (!blank) begin
            phase_d = PH_WDAY;
            name_go = 1'b1;
            npos    = '0;
            ncand   = ALL_CANDS;
          end
        end
        PH_MOLEAD: begin
          if (!blank) begin
            phase_d  = PH_MONTH;
            name_go  = 1'b1;
            is_month = 1'b1;
            npos     = '0;
            ncand    = ALL_CANDS;
          end
        end
        PH_WDAY: begin
          name_go = 1'b1;
        end
        PH_MONTH: begin
          name_go  = 1'b1;
          is_month = 1'b1;
        end
        // Day, hour, minute and second share one number parser
        PH_DAY, PH_HOUR, PH_MIN, PH_SEC: begin
          case (phase_q)
            PH_DAY: begin
              in_range = (num_q >= DAY_MIN) && (num_q <= DAY_MAX);
              num_next = PH_HOUR;
            end
            PH_HOUR: begin
              in_range   = (num_q <= HOUR_MAX);
              colon_next = 1'b1;
              num_next   = PH_MIN;
            end
            PH_MIN: begin
              in_range   = (num_q <= MINSEC_MAX);
              colon_next = 1'b1;
              num_next   = PH_SEC;
            end
            default: begin
              in_range = (num_q <= MINSEC_MAX);
              num_next = PH_YEAR;
            end
          endcase
          if (!seen_q && ws) begin
            // leading whitespace, skip
          end else if (!seen_q && !digit) begin
            held_d = V_NOTSEP;
          end else if (digit) begin
            num_d  = (prod > 11'(NUM_SAT)) ? NUM_SAT : prod[NumWidth-1:0];
            seen_d = 1'b1;
          end else if (!in_range) begin
            held_d = V_NOTSEP;
          end else begin
            num_d  = '0;
            seen_d = 1'b0;
            if (colon_next ? (c == ":") : ws) begin
              phase_d = num_next;
            end else begin
              held_d = V_NOTSEP;
            end
          end
        end
        PH_YEAR: begin
          if (digit) begin
            held_d = V_START;
          end else if (!ws) begin
            held_d = V_NOTSEP;
          end
        end
        default: begin
          held_d = V_NOTSEP;
        end
      endcase

      // Three-letter name matching
      if (name_go) begin
        if (npos >= NAME_LEN) begin
          if (blank) begin
            phase_d = is_month ? PH_DAY : PH_MOLEAD;
          end else begin
            held_d = V_NOTSEP;
          end
        end else begin
          keep   = name_hits(is_month, npos[1:0], c);
          cand_d = ncand & keep;
          pos_d  = npos + 3'd1;
          if ((ncand & keep) == '0) begin
            held_d = V_NOTSEP;
          end
        end
      end
    end

    // Line end: report and return to the line start state
    if (take_o && item_i.end_of_line) begin
      result_o.valid = 1'b1;
      if (held_d != V_UNDECIDED) begin
        result_o.verdict = held_d;
      end else if (phase_d == PH_ADDRLEAD || phase_d == PH_ADDR) begin
        result_o.verdict = V_NOSPACE;
      end else begin
        result_o.verdict = V_NOTSEP;
      end
      phase_d = PH_PREFIX;
      pos_d   = '0;
      cand_d  = ALL_CANDS;
      num_d   = '0;
      seen_d  = 1'b0;
      held_d  = V_UNDECIDED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      cand_q  <= ALL_CANDS;
      num_q   <= '0;
      seen_q  <= 1'b0;
      held_q  <= V_UNDECIDED;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cand_q  <= cand_d;
      num_q   <= num_d;
      seen_q  <= seen_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: src/mfld_out_stage.sv
// ----------------------------------------------------------------------------
// mfld_out_stage
// Result register: holds one verdict transaction until the sink takes it.
// ----------------------------------------------------------------------------
module mfld_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mfld_pkg::result_t      result_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             verdict_o
);
  import mfld_pkg::*;

  logic     valid_q, valid_d;
  verdict_e verdict_q;

  // Room when empty or being drained this cycle
  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      verdict_q <= result_i.verdict;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;

endmodule

FILE: src/mbox_from_line_detector.sv
// Path: an end-of-line transaction moves from the input register through the
//   parser into the result register when it is free; out_valid_o shows the verdict.
// Throughput: one character per cycle unless a line end waits on a stalled
//   result register; the per-character state update is a single parser pass.
// Reset: asynchronous, active low; parser returns to the line-start state and
//   both registers empty.
// ----------------------------------------------------------------------------
// mbox_from_line_detector
// Tests each text line against the mbox "From " separator format.
// ----------------------------------------------------------------------------
module mbox_from_line_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);
  import mfld_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    out_free;
  result_t result;

  mfld_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .end_of_line_i (end_of_line_i),
    .take_i        (take),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  mfld_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .result_o     (result)
  );

  mfld_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

endmodule

FILE: src/mfld_checker.sv
// ----------------------------------------------------------------------------
// mfld_checker
// Port-level checks for the separator line detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);
  import mfld_pkg::*;

  // Result transaction offered but held off by the sink
  logic out_held;
  assign out_held = out_valid_o && out_stall_i;

  // A stalled result transaction stays put
  `MFLD_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(verdict_o), "stalled result moved")

  // The undecided code never leaves the block
  `MFLD_ASSERT_ALWAYS(a_no_undecided, out_valid_o |-> verdict_o != V_UNDECIDED, "undecided code")

  // Input backpressure only comes from a blocked result register
  `MFLD_ASSERT(a_stall_cause, in_stall_o |-> out_held, "input stall without output stall")

endmodule

bind mbox_from_line_detector mfld_checker u_mfld_checker (.*);
